// ===== rtl/ael_pkg.sv =====
// ---------------------------------------------------------------------------
// ael_pkg: shared types and constants for the expression lexer
// Token kinds, error codes, character codes and the queue entry layout.
// ---------------------------------------------------------------------------
`default_nettype none

package ael_pkg;

    // Position counter width and saturation point
    localparam int unsigned POS_BITS = 16;
    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    // Output field widths
    localparam int unsigned VALUE_W = 63;
    localparam int unsigned TPOS_W  = 16;

    // Largest value that may still take one more decimal digit
    localparam logic [VALUE_W-1:0] VALUE_MUL_LIMIT = 63'h0CCC_CCCC_CCCC_CCCC;
    localparam logic [3:0]         VALUE_LAST_DIGIT = 4'd7;

    // Queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;

    typedef enum logic [3:0] {
        KIND_NUMBER = 4'd0,
        KIND_PLUS   = 4'd1,
        KIND_MINUS  = 4'd2,
        KIND_STAR   = 4'd3,
        KIND_SLASH  = 4'd4,
        KIND_LPAREN = 4'd5,
        KIND_RPAREN = 4'd6,
        KIND_END    = 4'd7,
        KIND_ERROR  = 4'd8
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_INVALID  = 2'd2
    } t_err;

    // One item's worth of tokens; only the first token can carry a value
    typedef struct packed {
        logic                 two;
        t_kind                kind0;
        logic [VALUE_W-1:0]   value0;
        logic [TPOS_W-1:0]    pos0;
        t_err                 err0;
        t_kind                kind1;
        logic [TPOS_W-1:0]    pos1;
        t_err                 err1;
    } t_entry;

    // Queue status seen by the back end
    typedef struct packed {
        logic   avail;
        t_entry entry;
    } t_qhead;

    // Map a position counter onto the 16-bit output field
    function automatic logic [TPOS_W-1:0] pos_field(input logic [POS_BITS-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        return w[TPOS_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/arith_expression_lexer_top.sv =====
// ---------------------------------------------------------------------------
// arith_expression_lexer_top: streaming arithmetic expression lexer
// Turns a byte stream into number, operator, end and error tokens.
// ---------------------------------------------------------------------------
// Usage:
//   Slave side carries one expression byte per item; tlast marks the closing
//   end item (its byte is ignored). Master side carries one token per item,
//   kind in tuser, value/position/error code in tdata; tlast marks the last
//   token caused by one input item.
//   Path: an accepted item's entry enters the queue at its accepting edge,
//   then moves into the output register once that register is empty or
//   sends its last token; its one or two tokens leave from there in order.
//   Throughput: one input item per cycle while the queue is not full. The
//   master side sends one token per cycle while the receiver is ready, so
//   an item causing two tokens (number then operator, error or end) holds
//   the output for both; a four-entry queue between the classifier and
//   the output sequencer absorbs these bursts.
//   Stall: while the receiver holds tready low the shown token stays put and
//   the queue fills; o_s_axis_tready drops only when the queue is full.
//   Reset: synchronous, active low; clears lexer state, queue and output.
// ---------------------------------------------------------------------------
`default_nettype none

module arith_expression_lexer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] char_byte
    input  wire logic        i_s_axis_tlast,   // is_end
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [87:0]      o_m_axis_tdata,   // [62:0] token_value, [78:63] token_position,
                                               // [80:79] error_code, [87:81] zero
    output logic [3:0]       o_m_axis_tuser,   // [3:0] token_kind
    output logic             o_m_axis_tlast    // last_of_run
);

    ael_pkg::t_entry               entry;
    ael_pkg::t_qhead               head;
    logic                          push;
    logic                          pop;
    logic                          full;
    logic                          fire_in;
    ael_pkg::t_kind                kind;
    logic [ael_pkg::VALUE_W-1:0]   value;
    logic [ael_pkg::TPOS_W-1:0]    pos;
    ael_pkg::t_err                 err;

    assign o_s_axis_tready = !full;
    assign fire_in         = i_s_axis_tvalid && !full;

    ael_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire_in),
        .i_char  (i_s_axis_tdata),
        .i_end   (i_s_axis_tlast),
        .o_entry (entry),
        .o_push  (push)
    );

    ael_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full)
    );

    ael_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_kind  (kind),
        .o_value (value),
        .o_pos   (pos),
        .o_err   (err),
        .o_last  (o_m_axis_tlast)
    );

    // Pack master payload
    assign o_m_axis_tuser = kind;
    assign o_m_axis_tdata = {7'd0, err, pos, value};

endmodule

`default_nettype wire

// ===== rtl/ael_front.sv =====
// ---------------------------------------------------------------------------
// ael_front: byte classifier and number accumulator
// Takes one byte or end item per cycle, updates the lexer state and builds
// the one or two tokens the item causes as a single queue entry.
// ---------------------------------------------------------------------------
`default_nettype none

module ael_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire logic [7:0]    i_char,
    input  wire logic          i_end,
    output ael_pkg::t_entry    o_entry,
    output logic               o_push
);

    logic [ael_pkg::VALUE_W-1:0]  r_acc,    n_acc;
    logic                         r_active, n_active;
    logic [ael_pkg::POS_BITS-1:0] r_start,  n_start;
    logic [ael_pkg::POS_BITS-1:0] r_pos,    n_pos;
    logic                         r_err,    n_err;

    logic                         char_digit;
    logic                         char_blank;
    logic                         is_op;
    ael_pkg::t_kind               op_kind;
    logic [3:0]                   digit;
    logic [ael_pkg::VALUE_W-1:0]  base;
    logic [ael_pkg::POS_BITS-1:0] start_v;
    logic                         ovf;
    ael_pkg::t_kind               kb;
    ael_pkg::t_err                eb;
    logic                         has_b;
    logic [ael_pkg::TPOS_W-1:0]   pos_f;
    logic [ael_pkg::TPOS_W-1:0]   start_f;

    // Classify the byte
    always_comb begin
        char_digit = (i_char >= ael_pkg::CHAR_ZERO) && (i_char <= ael_pkg::CHAR_NINE);
        char_blank = ((i_char >= ael_pkg::CHAR_TAB) && (i_char <= ael_pkg::CHAR_CR))
                     || (i_char == ael_pkg::CHAR_SPACE);
        digit      = 4'(i_char - ael_pkg::CHAR_ZERO);
        is_op      = 1'b1;
        unique case (i_char)
            ael_pkg::CHAR_PLUS:   op_kind = ael_pkg::KIND_PLUS;
            ael_pkg::CHAR_MINUS:  op_kind = ael_pkg::KIND_MINUS;
            ael_pkg::CHAR_STAR:   op_kind = ael_pkg::KIND_STAR;
            ael_pkg::CHAR_SLASH:  op_kind = ael_pkg::KIND_SLASH;
            ael_pkg::CHAR_LPAREN: op_kind = ael_pkg::KIND_LPAREN;
            ael_pkg::CHAR_RPAREN: op_kind = ael_pkg::KIND_RPAREN;
            default: begin
                op_kind = ael_pkg::KIND_ERROR;
                is_op   = 1'b0;
            end
        endcase
    end

    // Digit path: value so far and overflow check
    always_comb begin
        base    = r_active ? r_acc : '0;
        start_v = r_active ? r_start : r_pos;
        ovf     = (base > ael_pkg::VALUE_MUL_LIMIT)
                  || ((base == ael_pkg::VALUE_MUL_LIMIT) && (digit > ael_pkg::VALUE_LAST_DIGIT));
        pos_f   = ael_pkg::pos_field(r_pos);
        start_f = ael_pkg::pos_field(r_start);
        // Operator or error token that a non-digit byte may give
        has_b   = is_op || !char_blank;
        kb      = is_op ? op_kind : ael_pkg::KIND_ERROR;
        eb      = is_op ? ael_pkg::ERR_NONE : ael_pkg::ERR_INVALID;
    end

    // Next state and token entry
    always_comb begin
        n_acc    = r_acc;
        n_active = r_active;
        n_start  = r_start;
        n_pos    = r_pos;
        n_err    = r_err;
        o_push   = 1'b0;
        o_entry  = '{two: 1'b0, kind0: ael_pkg::KIND_NUMBER, value0: '0, pos0: '0,
                     err0: ael_pkg::ERR_NONE, kind1: ael_pkg::KIND_NUMBER, pos1: '0,
                     err1: ael_pkg::ERR_NONE};
        if (i_fire) begin
            if (i_end) begin
                // Unless halted by an error, flush number and emit end token; then clear everything
                if (!r_err) begin
                    o_push = 1'b1;
                    if (r_active) begin
                        o_entry.two    = 1'b1;
                        o_entry.kind0  = ael_pkg::KIND_NUMBER;
                        o_entry.value0 = r_acc;
                        o_entry.pos0   = start_f;
                        o_entry.kind1  = ael_pkg::KIND_END;
                        o_entry.pos1   = pos_f;
                    end else begin
                        o_entry.kind0  = ael_pkg::KIND_END;
                        o_entry.pos0   = pos_f;
                    end
                end
                n_acc    = '0;
                n_active = 1'b0;
                n_start  = '0;
                n_pos    = '0;
                n_err    = 1'b0;
            end else if (!r_err) begin
                if (char_digit) begin
                    if (ovf) begin
                        o_push        = 1'b1;
                        o_entry.kind0 = ael_pkg::KIND_ERROR;
                        o_entry.pos0  = ael_pkg::pos_field(start_v);
                        o_entry.err0  = ael_pkg::ERR_OVERFLOW;
                        n_err         = 1'b1;
                        n_active      = 1'b0;
                        n_acc         = '0;
                        n_start       = start_v;
                    end else begin
                        // x10 as two shifts and an add
                        n_acc    = (base << 3) + (base << 1) + ael_pkg::VALUE_W'(digit);
                        n_active = 1'b1;
                        n_start  = start_v;
                    end
                end else begin
                    if (r_active) begin
                        o_push         = 1'b1;
                        o_entry.two    = has_b;
                        o_entry.kind0  = ael_pkg::KIND_NUMBER;
                        o_entry.value0 = r_acc;
                        o_entry.pos0   = start_f;
                        o_entry.kind1  = kb;
                        o_entry.pos1   = pos_f;
                        o_entry.err1   = eb;
                    end else begin
                        o_push         = has_b;
                        o_entry.kind0  = kb;
                        o_entry.pos0   = pos_f;
                        o_entry.err0   = eb;
                    end
                    n_active = 1'b0;
                    n_acc    = '0;
                    if (!is_op && !char_blank) begin
                        n_err = 1'b1;
                    end
                end
                // Advance position, saturating
                if (r_pos != ael_pkg::POS_MAX) begin
                    n_pos = r_pos + 1'b1;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_active <= 1'b0;
            r_start  <= '0;
            r_pos    <= '0;
            r_err    <= 1'b0;
        end else begin
            r_acc    <= n_acc;
            r_active <= n_active;
            r_start  <= n_start;
            r_pos    <= n_pos;
            r_err    <= n_err;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ael_queue.sv =====
// ---------------------------------------------------------------------------
// ael_queue: short FIFO of token entries
// Decouples the classifier from the output side; one push and one pop per
// cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ael_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire ael_pkg::t_entry  i_entry,
    input  wire logic             i_pop,
    output ael_pkg::t_qhead       o_head,
    output logic                  o_full
);

    ael_pkg::t_entry             r_mem [ael_pkg::QUEUE_DEPTH];
    logic [ael_pkg::QPTR_W-1:0]  r_wr, n_wr;
    logic [ael_pkg::QPTR_W-1:0]  r_rd, n_rd;
    logic [ael_pkg::QCNT_W-1:0]  r_cnt, n_cnt;
    logic                        do_pop;

    assign o_full       = (r_cnt == ael_pkg::QCNT_W'(ael_pkg::QUEUE_DEPTH));
    assign o_head.avail = (r_cnt != '0);
    assign o_head.entry = r_mem[r_rd];
    assign do_pop       = i_pop && o_head.avail;

    // Advance pointers and count
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == ael_pkg::QPTR_W'(ael_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == ael_pkg::QPTR_W'(ael_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ael_back.sv =====
// ---------------------------------------------------------------------------
// ael_back: token sequencer and output register
// Holds one queue entry and sends its one or two tokens on the master side,
// marking the last token of the entry.
// ---------------------------------------------------------------------------
`default_nettype none

module ael_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ael_pkg::t_qhead              i_head,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output ael_pkg::t_kind                    o_kind,
    output logic [ael_pkg::VALUE_W-1:0]       o_value,
    output logic [ael_pkg::TPOS_W-1:0]        o_pos,
    output ael_pkg::t_err                     o_err,
    output logic                              o_last
);

    ael_pkg::t_entry r_ent;
    logic            r_have, n_have;
    logic            r_idx,  n_idx;
    logic            fire;

    assign fire    = r_have && i_ready;
    assign o_valid = r_have;
    assign o_last  = r_idx || !r_ent.two;

    // Select the token being shown
    always_comb begin
        if (r_idx) begin
            o_kind  = r_ent.kind1;
            o_value = '0;
            o_pos   = r_ent.pos1;
            o_err   = r_ent.err1;
        end else begin
            o_kind  = r_ent.kind0;
            o_value = r_ent.value0;
            o_pos   = r_ent.pos0;
            o_err   = r_ent.err0;
        end
    end

    // Step through the entry, load the next one when done
    always_comb begin
        n_have = r_have;
        n_idx  = r_idx;
        o_pop  = 1'b0;
        if (!r_have || (fire && o_last)) begin
            o_pop  = i_head.avail;
            n_have = i_head.avail;
            n_idx  = 1'b0;
        end else if (fire) begin
            n_idx = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_idx  <= 1'b0;
        end else begin
            r_have <= n_have;
            r_idx  <= n_idx;
        end
    end

    // Hold entry payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_head.entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ael_checker.sv =====
// ---------------------------------------------------------------------------
// ael_checker: port-level checks for the expression lexer
// Watches the master side for reset, hold and token field consistency.
// ---------------------------------------------------------------------------
`default_nettype none

module ael_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [87:0] o_m_axis_tdata,
    input  wire logic [3:0]  o_m_axis_tuser,
    input  wire logic        o_m_axis_tlast
);

    // Reset empties the output
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // Stalled token holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled token changed");

    // Only error tokens carry an error code, and they always do
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((o_m_axis_tuser == ael_pkg::KIND_ERROR)
             == (o_m_axis_tdata[80:79] != ael_pkg::ERR_NONE)))
        else $error("error code does not match token kind");

    // Only number tokens carry a value
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != ael_pkg::KIND_NUMBER) |->
            (o_m_axis_tdata[62:0] == '0))
        else $error("value on non-number token");

    // An end token always ends its run
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == ael_pkg::KIND_END) |-> o_m_axis_tlast)
        else $error("end token not last of run");

endmodule

bind arith_expression_lexer_top ael_checker u_ael_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire

// ===== tb/sv/arith_expression_lexer_checker.sv =====
// ---------------------------------------------------------------------------
// arith_expression_lexer_checker: token predictor and scoreboard
// Watches both stream channels of the lexer, works out the tokens each
// accepted byte must cause and compares every token that leaves the block.
// ---------------------------------------------------------------------------
`default_nettype none

module arith_expression_lexer_checker
    import ael_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        i_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] char_byte
    input  wire logic        i_s_axis_tlast,   // is_end
    input  wire logic        i_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [87:0] i_m_axis_tdata,   // [62:0] token_value, [78:63] token_position,
                                               // [80:79] error_code, [87:81] zero
    input  wire logic [3:0]  i_m_axis_tuser,   // [3:0] token_kind
    input  wire logic        i_m_axis_tlast,   // last_of_run
    output int               o_fail_count,
    output int               o_pending,
    output int               o_token_count,
    output int               o_error_count,
    output int               o_overflow_count
);

    timeunit 1ns;
    timeprecision 1ps;

    // Largest value that still accepts one more digit, and the last digit allowed then
    localparam logic [VALUE_W-1:0] VALUE_TOP    = '1;
    localparam logic [VALUE_W-1:0] TEN_LIMIT    = VALUE_TOP / 10;
    localparam logic [VALUE_W-1:0] TOP_DIGIT    = VALUE_TOP % 10;

    typedef struct {
        t_kind              kind;
        logic [VALUE_W-1:0] value;
        logic [TPOS_W-1:0]  pos;
        t_err               err;
        logic               last;
    } t_lex_token;

    // Lexer state as seen from outside
    logic [VALUE_W-1:0]  acc_value;
    logic                in_number;
    logic [POS_BITS-1:0] num_start;
    logic [POS_BITS-1:0] byte_pos;
    logic                halted;

    t_lex_token expected_tokens[$];

    // Queue one token behind the ones already waiting
    function automatic void push_token(t_kind kind, logic [VALUE_W-1:0] value,
                                       logic [POS_BITS-1:0] pos, t_err err);
        t_lex_token t;
        t.kind  = kind;
        t.value = value;
        t.pos   = TPOS_W'(pos);
        t.err   = err;
        t.last  = 1'b0;
        expected_tokens = {expected_tokens, t};
        if (kind == KIND_ERROR) o_error_count++;
        if (err == ERR_OVERFLOW) o_overflow_count++;
    endfunction

    function automatic void clear_lexer();
        acc_value = '0;
        in_number = 1'b0;
        num_start = '0;
        byte_pos  = '0;
        halted    = 1'b0;
    endfunction

    // Work out the tokens that one accepted byte or end item causes
    function automatic void lex_item(logic [7:0] ch, logic is_end);
        int          first;
        logic [3:0]  digit;
        t_kind       op;
        logic        is_op;
        logic        blank_byte;
        first      = expected_tokens.size();
        digit      = 4'(ch - CHAR_ZERO);
        is_op      = 1'b1;
        op         = KIND_PLUS;
        blank_byte = (ch >= CHAR_TAB && ch <= CHAR_CR) || ch == CHAR_SPACE;
        case (ch)
            CHAR_PLUS:   op = KIND_PLUS;
            CHAR_MINUS:  op = KIND_MINUS;
            CHAR_STAR:   op = KIND_STAR;
            CHAR_SLASH:  op = KIND_SLASH;
            CHAR_LPAREN: op = KIND_LPAREN;
            CHAR_RPAREN: op = KIND_RPAREN;
            default:     is_op = 1'b0;
        endcase

        if (is_end) begin
            // unless halted, flush the open number and close the expression; re-arm
            if (!halted) begin
                if (in_number) push_token(KIND_NUMBER, acc_value, num_start, ERR_NONE);
                push_token(KIND_END, '0, byte_pos, ERR_NONE);
            end
            clear_lexer();
        end else if (!halted) begin
            if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                if (!in_number) begin
                    in_number = 1'b1;
                    num_start = byte_pos;
                    acc_value = '0;
                end
                if (acc_value > TEN_LIMIT ||
                    (acc_value == TEN_LIMIT && VALUE_W'(digit) > TOP_DIGIT)) begin
                    push_token(KIND_ERROR, '0, num_start, ERR_OVERFLOW);
                    halted    = 1'b1;
                    in_number = 1'b0;
                    acc_value = '0;
                end else begin
                    acc_value = acc_value * 10 + VALUE_W'(digit);
                end
            end else begin
                // any non-digit closes a number first
                if (in_number) begin
                    push_token(KIND_NUMBER, acc_value, num_start, ERR_NONE);
                    in_number = 1'b0;
                    acc_value = '0;
                end
                if (is_op) begin
                    push_token(op, '0, byte_pos, ERR_NONE);
                end else if (!blank_byte) begin
                    push_token(KIND_ERROR, '0, byte_pos, ERR_INVALID);
                    halted = 1'b1;
                end
            end
            // saturate the position counter
            if (byte_pos != POS_MAX) byte_pos = byte_pos + 1'b1;
        end

        if (expected_tokens.size() > first)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_val,
                                        logic [63:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            o_fail_count++;
        end
    endfunction

    // Predict on input items, compare on output items
    always @(posedge i_clk) begin
        t_lex_token t;
        if (!i_rst_n) begin
            clear_lexer();
            expected_tokens.delete();
            o_fail_count     = 0;
            o_token_count    = 0;
            o_error_count    = 0;
            o_overflow_count = 0;
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                lex_item(i_s_axis_tdata, i_s_axis_tlast);
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                o_token_count++;
                if (expected_tokens.size() == 0) begin
                    $error("unexpected token: kind %0d, position %0d",
                           i_m_axis_tuser, i_m_axis_tdata[78:63]);
                    o_fail_count++;
                end else begin
                    t = expected_tokens.pop_front();
                    check_field("token_kind", 64'(t.kind), 64'(i_m_axis_tuser));
                    check_field("token_value", 64'(t.value), 64'(i_m_axis_tdata[62:0]));
                    check_field("token_position", 64'(t.pos), 64'(i_m_axis_tdata[78:63]));
                    check_field("error_code", 64'(t.err), 64'(i_m_axis_tdata[80:79]));
                    check_field("last_of_run", 64'(t.last), 64'(i_m_axis_tlast));
                end
            end
        end
        o_pending = expected_tokens.size();
    end

endmodule

`default_nettype wire

// ===== tb/sv/arith_expression_lexer_top_tb.sv =====
// ---------------------------------------------------------------------------
// arith_expression_lexer_top_tb: stimulus and verdict for the lexer
// Feeds directed and random expressions under three idling mixes, with a
// long receiver stall in each; the checker scores.
// ---------------------------------------------------------------------------
`default_nettype none

module arith_expression_lexer_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ael_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic [87:0] m_data;
    logic [3:0]  m_user;
    logic        m_last;

    int fail_count;
    int pending;
    int token_count;
    int error_count;
    int overflow_count;

    int items_sent     = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_cycles;
    bit hold_req       = 1'b0;

    string edge_numbers[5] = '{"9223372036854775807", "9223372036854775808",
                               "922337203685477580", "99999999999999999999",
                               "000000000000000000000042"};

    arith_expression_lexer_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    arith_expression_lexer_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_axis_tvalid  (s_valid),
        .i_s_axis_tready  (s_ready),
        .i_s_axis_tdata   (s_data),
        .i_s_axis_tlast   (s_last),
        .i_m_axis_tvalid  (m_valid),
        .i_m_axis_tready  (m_ready),
        .i_m_axis_tdata   (m_data),
        .i_m_axis_tuser   (m_user),
        .i_m_axis_tlast   (m_last),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_token_count    (token_count),
        .o_error_count    (error_count),
        .o_overflow_count (overflow_count)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, or a long hold-off when asked for
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("arith_expression_lexer_top_tb NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one item, with random idle cycles ahead of it; return after acceptance
    task automatic send_item(logic [7:0] b, logic is_end);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= is_end;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(string txt);
        for (int i = 0; i < txt.len(); i++) send_item(txt[i], 1'b0);
    endtask

    // Close the expression; the byte rides along and must be ignored
    task automatic send_end();
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_number();
        int r;
        int len;
        r = $urandom_range(19);
        if (r == 0) begin
            send_text(edge_numbers[$urandom_range(4)]);
        end else begin
            len = (r == 1) ? $urandom_range(17, 20) : $urandom_range(1, 5);
            repeat (len) send_item(8'(CHAR_ZERO + $urandom_range(9)), 1'b0);
        end
    endtask

    // One whitespace byte: tab through carriage return, or a space
    task automatic send_space();
        int r;
        r = $urandom_range(5);
        send_item((r == 5) ? CHAR_SPACE : 8'(CHAR_TAB + r), 1'b0);
    endtask

    // One random expression: mostly well formed, some broken, some noise
    task automatic rand_expression();
        string      ops;
        int         mode;
        int         pick;
        logic [7:0] b;
        ops  = "+-*/()";
        mode = $urandom_range(99);
        if (mode < 8) begin
            repeat ($urandom_range(1, 10)) send_item(8'($urandom_range(255)), 1'b0);
        end else begin
            repeat ($urandom_range(1, 8)) begin
                pick = $urandom_range(9);
                if (pick < 4) begin
                    send_number();
                end else if (pick < 8) begin
                    send_item(ops[$urandom_range(5)], 1'b0);
                end else if (pick == 9 && mode < 20) begin
                    // drop in a byte that is no token and no whitespace
                    do b = 8'($urandom_range(255));
                    while ((b >= CHAR_ZERO && b <= CHAR_NINE) ||
                           b inside {CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH,
                                     CHAR_LPAREN, CHAR_RPAREN, CHAR_SPACE} ||
                           (b >= CHAR_TAB && b <= CHAR_CR));
                    send_item(b, 1'b0);
                end else begin
                    send_space();
                end
                if ($urandom_range(3) == 0) send_space();
            end
        end
        send_end();
    endtask

    // Stop offering and wait for every expected token
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // Main stimulus
    initial begin
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        s_last  = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Sender mostly busy, receiver mostly stalled
        send_idle_pct = 7;
        recv_idle_pct = 61;

        // Directed: empty expression, all operators but plus, number flushes, bad bytes
        send_end();
        send_text("(9-0)*1/ 2");
        send_end();
        send_item(8'h35, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h31, 1'b0);
        send_end();
        send_item(8'h00, 1'b0);
        send_end();
        send_item(8'h34, 1'b0);
        send_item(CHAR_CR, 1'b0);
        send_item(8'h35, 1'b0);
        send_end();

        hold_req = 1'b1;
        while (items_sent < 450) rand_expression();
        wait_drained();

        // Sender mostly idle, receiver mostly ready
        send_idle_pct = 61;
        recv_idle_pct = 7;
        hold_req = 1'b1;
        while (items_sent < 900) rand_expression();
        wait_drained();

        // Back to back on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        while (items_sent < 1300) rand_expression();
        wait_drained();

        repeat (8) @(posedge i_clk);
        $display("Covered %0d input items and %0d tokens (%0d errors, %0d overflows),",
                 items_sent, token_count, error_count, overflow_count);
        $display("three idling mixes with a long receiver stall in each.");
        if (fail_count == 0) begin
            $display("arith_expression_lexer_top_tb OK");
        end else begin
            $display("arith_expression_lexer_top_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
